// ===== sv/tedq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event dispatch queue: shared definitions
// Field widths, result codes and the control store of the sequencer.
// ----------------------------------------------------------------------------
package tedq_pkg;

	// Field widths.
	localparam int TIME_W     = 31;
	localparam int TAG_IN_W   = 16;
	localparam int STATUS_W   = 3;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 80;

	// Default sizing.
	localparam int DEF_QUEUE_SLOTS = 16;
	localparam int DEF_TAG_BITS    = 16;

	// Request kinds.
	localparam logic ACT_ENQUEUE  = 1'b0;
	localparam logic ACT_DISPATCH = 1'b1;

	// Result codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_QUIT     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

	// Step addresses of the control program.
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
	localparam logic [STEP_W-1:0] STEP_ENQ   = 3'd1;
	localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_DISP  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_SCAN  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd5;
	localparam logic [STEP_W-1:0] STEP_MOVE  = 3'd6;

	// Branch conditions.
	localparam logic [2:0] COND_NEVER     = 3'd0;
	localparam logic [2:0] COND_ALWAYS    = 3'd1;
	localparam logic [2:0] COND_NO_REQ    = 3'd2;
	localparam logic [2:0] COND_IN_DISP   = 3'd3;
	localparam logic [2:0] COND_REJECT    = 3'd4;
	localparam logic [2:0] COND_SCAN_MORE = 3'd5;
	localparam logic [2:0] COND_OUT_BUSY  = 3'd6;

	// Datapath operations.
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_FETCH = 3'd1;
	localparam logic [2:0] OP_ENQ   = 3'd2;
	localparam logic [2:0] OP_EMIT  = 3'd3;
	localparam logic [2:0] OP_CHECK = 3'd4;
	localparam logic [2:0] OP_SCAN  = 3'd5;
	localparam logic [2:0] OP_DRAIN = 3'd6;
	localparam logic [2:0] OP_MOVE  = 3'd7;

	// One control word: hold the step, else branch, else fall through.
	typedef struct packed {
		logic [2:0]        op;
		logic [2:0]        hold_cond;
		logic [2:0]        jump_cond;
		logic [STEP_W-1:0] target;
	} ucw_t;

	// Control store.
	function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
		ucw_t w;
		w = '{op: OP_NONE, hold_cond: COND_NEVER, jump_cond: COND_ALWAYS,
			target: STEP_FETCH};
		case (step)
			STEP_FETCH: w = '{op: OP_FETCH, hold_cond: COND_NO_REQ,
				jump_cond: COND_IN_DISP, target: STEP_DISP};
			STEP_ENQ:   w = '{op: OP_ENQ, hold_cond: COND_NEVER,
				jump_cond: COND_NEVER, target: STEP_FETCH};
			STEP_EMIT:  w = '{op: OP_EMIT, hold_cond: COND_OUT_BUSY,
				jump_cond: COND_ALWAYS, target: STEP_FETCH};
			STEP_DISP:  w = '{op: OP_CHECK, hold_cond: COND_NEVER,
				jump_cond: COND_REJECT, target: STEP_EMIT};
			STEP_SCAN:  w = '{op: OP_SCAN, hold_cond: COND_SCAN_MORE,
				jump_cond: COND_NEVER, target: STEP_FETCH};
			STEP_DRAIN: w = '{op: OP_DRAIN, hold_cond: COND_NEVER,
				jump_cond: COND_NEVER, target: STEP_FETCH};
			STEP_MOVE:  w = '{op: OP_MOVE, hold_cond: COND_NEVER,
				jump_cond: COND_ALWAYS, target: STEP_EMIT};
			default:    w = '{op: OP_NONE, hold_cond: COND_NEVER,
				jump_cond: COND_ALWAYS, target: STEP_FETCH};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/timed_event_dispatch_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event dispatch queue
// Ring of timed events with enqueue and earliest-first dispatch.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ stream: tuser selects enqueue (0) or dispatch (1),
// tdata carries the delay and the event tag. Every request gives exactly one
// result on the m_ stream: tuser is the status, tdata the dispatched tag and
// time (zero unless a dispatch succeeded) and the current time.
// The time limit is written through cfg_wr_en / cfg_wr_data while idle.
// Requests are handled one at a time by a small microcoded sequencer.
// An enqueue passes from acceptance through the enqueue and emit steps, a
// rejected dispatch through the check and emit steps, and a dispatch over n
// stored events through the check, scan, drain, move and emit steps: the scan
// reads one slot per cycle through the single read port of the slot memory,
// so a full ring of 15 events takes 15 reads. Results are registered at emit.
// Results sit in an output register; a new request is taken while a result
// waits, and the sequencer holds only when its next result finds the output
// register still occupied. Reset empties the ring, clears the time and the
// limit; slot contents are not cleared and no clearing pass is needed.
module timed_event_dispatch_queue_top #(
	parameter int QUEUE_SLOTS = tedq_pkg::DEF_QUEUE_SLOTS,
	parameter int TAG_BITS    = tedq_pkg::DEF_TAG_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [30:0] delay, [46:31] event_tag, [47] zero.
	input  logic [tedq_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] action.
	input  logic                            s_tuser,
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] due_tag, [46:16] due_time, [77:47] current_time, [79:78] zero.
	output logic [tedq_pkg::OUT_DATA_W-1:0] m_tdata,
	// [2:0] status.
	output logic [tedq_pkg::STATUS_W-1:0]   m_tuser,
	// Time limit register.
	input  logic                            cfg_wr_en,
	input  logic [tedq_pkg::TIME_W-1:0]     cfg_wr_data
);

	localparam int TimeW = tedq_pkg::TIME_W;
	localparam int TagW  = (TAG_BITS < tedq_pkg::TAG_IN_W) ? TAG_BITS : tedq_pkg::TAG_IN_W;
	localparam int IdxW  = $clog2(QUEUE_SLOTS);
	localparam int WordW = TimeW + TagW;

	function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] i);
		return (i == IdxW'(QUEUE_SLOTS - 1)) ? '0 : i + 1'b1;
	endfunction

	// Sequencer state and control word.
	logic [tedq_pkg::STEP_W-1:0] upc_q;
	tedq_pkg::ucw_t              ucw;

	// Architectural state.
	logic [IdxW-1:0]  head_q, tail_q, scan_ptr_q;
	logic [TimeW-1:0] now_q, limit_q;

	// Latched request.
	logic             act_q;
	logic [TimeW-1:0] delay_q;
	logic [TagW-1:0]  tag_q;

	// Pending result.
	logic [tedq_pkg::STATUS_W-1:0] res_status_q;
	logic [tedq_pkg::TAG_IN_W-1:0] res_tag_q;
	logic [TimeW-1:0]              res_time_q;

	// Output register.
	logic                            out_vld_q;
	logic [tedq_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [tedq_pkg::STATUS_W-1:0]   out_status_q;

	// Slot memory and scan datapath.
	logic [WordW-1:0] slot_mem [QUEUE_SLOTS];
	logic [WordW-1:0] rd_data_s1;
	logic             rd_vld_s1;
	logic [IdxW-1:0]  rd_idx_s1;
	logic [IdxW-1:0]  rd_addr;
	logic             mem_we;
	logic [IdxW-1:0]  wr_addr;
	logic [WordW-1:0] wr_data;
	logic             best_vld_q;
	logic [IdxW-1:0]  best_idx_q;
	logic [TimeW-1:0] best_time_q;
	logic [TagW-1:0]  best_tag_q;
	logic [TimeW-1:0] rd_time;
	logic [TagW-1:0]  rd_tag;

	// Status of the current request.
	logic [TimeW:0] due_sum;
	logic           ring_full, ring_empty, quit, overflow, reject, out_busy;
	logic           in_accept, hold, jump;

	assign ucw        = tedq_pkg::ucode(upc_q);
	assign s_tready   = (ucw.op == tedq_pkg::OP_FETCH);
	assign in_accept  = s_tvalid && s_tready;
	assign due_sum    = {1'b0, now_q} + {1'b0, delay_q};
	assign overflow   = due_sum[TimeW];
	assign ring_full  = (ring_next(tail_q) == head_q);
	assign ring_empty = (head_q == tail_q);
	assign quit       = (limit_q != '0) && (now_q > limit_q);
	assign reject     = quit || ring_empty;
	assign out_busy   = out_vld_q && !m_tready;
	assign rd_time    = rd_data_s1[TimeW-1:0];
	assign rd_tag     = rd_data_s1[TimeW +: TagW];

	// Condition evaluation.
	function automatic logic cond_met(input logic [2:0] c, input logic no_req,
			input logic in_disp, input logic rej, input logic more, input logic busy);
		logic r;
		r = 1'b0;
		case (c)
			tedq_pkg::COND_NEVER:     r = 1'b0;
			tedq_pkg::COND_ALWAYS:    r = 1'b1;
			tedq_pkg::COND_NO_REQ:    r = no_req;
			tedq_pkg::COND_IN_DISP:   r = in_disp;
			tedq_pkg::COND_REJECT:    r = rej;
			tedq_pkg::COND_SCAN_MORE: r = more;
			tedq_pkg::COND_OUT_BUSY:  r = busy;
			default:                  r = 1'b0;
		endcase
		return r;
	endfunction

	assign hold = cond_met(ucw.hold_cond, !s_tvalid, s_tuser == tedq_pkg::ACT_DISPATCH,
		reject, ring_next(scan_ptr_q) != tail_q, out_busy);
	assign jump = cond_met(ucw.jump_cond, !s_tvalid, s_tuser == tedq_pkg::ACT_DISPATCH,
		reject, ring_next(scan_ptr_q) != tail_q, out_busy);

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= tedq_pkg::STEP_FETCH;
		end else if (hold) begin
			upc_q <= upc_q;
		end else if (jump) begin
			upc_q <= ucw.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_q   <= s_tuser;
			delay_q <= s_tdata[TimeW-1:0];
			tag_q   <= s_tdata[TimeW +: TagW];
		end
	end

	// Time limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Ring pointers and current time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			now_q  <= '0;
		end else begin
			if (ucw.op == tedq_pkg::OP_ENQ && !ring_full && !overflow) begin
				tail_q <= ring_next(tail_q);
			end
			if (ucw.op == tedq_pkg::OP_MOVE) begin
				head_q <= ring_next(head_q);
				now_q  <= best_time_q;
			end
		end
	end

	// Result of the current request.
	always_ff @(posedge clk) begin
		case (ucw.op)
			tedq_pkg::OP_ENQ: begin
				res_status_q <= ring_full ? tedq_pkg::ST_FULL :
					overflow ? tedq_pkg::ST_OVERFLOW : tedq_pkg::ST_OK;
				res_tag_q    <= '0;
				res_time_q   <= '0;
			end
			tedq_pkg::OP_CHECK: begin
				res_status_q <= quit ? tedq_pkg::ST_QUIT : tedq_pkg::ST_EMPTY;
				res_tag_q    <= '0;
				res_time_q   <= '0;
			end
			tedq_pkg::OP_MOVE: begin
				res_status_q <= tedq_pkg::ST_OK;
				res_tag_q    <= tedq_pkg::TAG_IN_W'(best_tag_q);
				res_time_q   <= best_time_q;
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
	end

	// Slot memory write: new event at the tail, or the head entry into the
	// slot that the dispatched event leaves.
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = tail_q;
		wr_data = {tag_q, due_sum[TimeW-1:0]};
		if (ucw.op == tedq_pkg::OP_ENQ) begin
			mem_we = !ring_full && !overflow;
		end else if (ucw.op == tedq_pkg::OP_MOVE) begin
			mem_we  = 1'b1;
			wr_addr = best_idx_q;
			wr_data = rd_data_s1;
		end
	end

	// The scan walks the ring; otherwise the head slot is read.
	assign rd_addr = (ucw.op == tedq_pkg::OP_SCAN) ? scan_ptr_q : head_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= slot_mem[rd_addr];
		rd_idx_s1  <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (ucw.op == tedq_pkg::OP_SCAN);
		end
	end

	// Scan pointer.
	always_ff @(posedge clk) begin
		if (ucw.op == tedq_pkg::OP_CHECK) begin
			scan_ptr_q <= head_q;
		end else if (ucw.op == tedq_pkg::OP_SCAN) begin
			scan_ptr_q <= ring_next(scan_ptr_q);
		end
	end

	// Running minimum; a strict compare keeps the first of equal times in scan order from the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
		end else if (ucw.op == tedq_pkg::OP_CHECK) begin
			best_vld_q <= 1'b0;
		end else if (rd_vld_s1) begin
			best_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && (!best_vld_q || rd_time < best_time_q)) begin
			best_idx_q  <= rd_idx_s1;
			best_time_q <= rd_time;
			best_tag_q  <= rd_tag;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ucw.op == tedq_pkg::OP_EMIT && !out_busy) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ucw.op == tedq_pkg::OP_EMIT && !out_busy) begin
			out_data_q   <= tedq_pkg::OUT_DATA_W'({now_q, res_time_q, res_tag_q});
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

`ifndef SYNTHESIS
	// The head only advances at the end of a successful dispatch.
	a_head_moves_on_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(head_q) |-> ($past(upc_q) == tedq_pkg::STEP_MOVE))
		else $error("head pointer moved outside a dispatch");

	// The tail only advances on an enqueue of a latched enqueue request.
	a_tail_moves_on_enqueue: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tail_q) |-> ($past(upc_q) == tedq_pkg::STEP_ENQ &&
			$past(act_q) == tedq_pkg::ACT_ENQUEUE))
		else $error("tail pointer moved outside an enqueue");

	// A dispatch never completes on an empty ring.
	a_move_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == tedq_pkg::STEP_MOVE) |-> (head_q != tail_q && best_vld_q))
		else $error("dispatch completed without a scanned event");

	// A new result is only presented after the emit step.
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(upc_q) == tedq_pkg::STEP_EMIT))
		else $error("result presented outside the emit step");
`endif

endmodule
